// File: hdl/vmb_pkg.sv
package vmb_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN           = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL  = 3'd6;

	// field widths
	localparam int LEVEL_W = 10;
	localparam int GAIN_W  = 12;
	localparam int TIME_W  = 32;
	localparam int HOLD_W  = 16;
	localparam int BRI_W   = 12;
	localparam int CNT_W   = 5;
	localparam int FCH_W   = 8;
	localparam int CHAN_W  = 9;

	// Q10 scaling
	localparam int FRAC_BITS = 10;
	localparam int PROD_W    = LEVEL_W + GAIN_W;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// register reset values
	localparam logic [GAIN_W-1:0]  GAIN_RST    = 12'd1024;
	localparam logic [LEVEL_W-1:0] TRIG_RST    = 10'd400;
	localparam logic [LEVEL_W-1:0] DECAY_RST   = 10'd30;
	localparam logic [HOLD_W-1:0]  HOLD_RST    = 16'd0;
	localparam logic [BRI_W-1:0]   MAXBRI_RST  = 12'd4095;
	localparam logic [CNT_W-1:0]   LEDCNT_RST  = 5'd16;
	localparam logic [FCH_W-1:0]   FIRSTCH_RST = 8'd0;

	// level queue between front and back
	localparam int LQ_DEPTH = 4;
	localparam int LQ_PTR_W = $clog2(LQ_DEPTH);

	// shared divider
	localparam int DIV_DW = PROD_W;
	localparam int DIV_VW = FRAC_BITS + 1;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain;
		logic [LEVEL_W-1:0] trigger_level;
		logic [LEVEL_W-1:0] decay_step;
		logic [HOLD_W-1:0]  holdoff_ms;
		logic [BRI_W-1:0]   max_brightness;
		logic [CNT_W-1:0]   led_count;
		logic [FCH_W-1:0]   first_channel;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FULL,
		BK_SPAN,
		BK_QUOT,
		BK_PROD,
		BK_PART,
		BK_EMIT
	} back_state_t;

endpackage

// File: hdl/vmb_front.sv
module vmb_front import vmb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               accept,
	input  logic [LEVEL_W-1:0] level,
	input  logic [TIME_W-1:0]  now_ms,
	output logic [LEVEL_W-1:0] held_next
);

	logic [LEVEL_W-1:0]          held_q;
	logic [TIME_W-1:0]           last_trig_q;
	logic [PROD_W-1:0]           prod;
	logic [PROD_W-FRAC_BITS-1:0] scaled_wide;
	logic [LEVEL_W-1:0]          scaled;
	logic [TIME_W-1:0]           elapsed;
	logic [LEVEL_W-1:0]          decayed;
	logic                        trig;

	// gain and saturate
	assign prod        = {{GAIN_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, cfg.gain};
	assign scaled_wide = prod[PROD_W-1:FRAC_BITS];
	assign scaled      = (scaled_wide > (PROD_W-FRAC_BITS)'(LEVEL_MAX)) ?
		LEVEL_MAX : scaled_wide[LEVEL_W-1:0];

	// trigger decision
	assign elapsed = now_ms - last_trig_q;
	assign trig    = (scaled >= held_q) && (scaled >= cfg.trigger_level) &&
		(elapsed > TIME_W'(cfg.holdoff_ms));
	assign decayed = (held_q >= cfg.decay_step) ? (held_q - cfg.decay_step) : '0;

	assign held_next = trig ? scaled : decayed;

	// held level and trigger time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			last_trig_q <= '0;
		end else if (accept) begin
			held_q <= held_next;
			if (trig) begin
				last_trig_q <= now_ms;
			end
		end
	end

endmodule

// File: hdl/vmb_fifo.sv
module vmb_fifo import vmb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [LEVEL_W-1:0] wdata,
	input  logic               rd_en,
	output logic [LEVEL_W-1:0] rdata,
	output logic               full,
	output logic               empty
);

	logic [LEVEL_W-1:0]  mem_q [LQ_DEPTH];
	logic [LQ_PTR_W-1:0] wptr_q;
	logic [LQ_PTR_W-1:0] rptr_q;
	logic [LQ_PTR_W:0]   count_q;

	assign full  = (count_q == (LQ_PTR_W+1)'(LQ_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/vmb_div.sv
module vmb_div import vmb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(DIV_DW + 1);

	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_VW:0]   shifted;
	logic [DIV_VW:0]   diff;
	logic              ge;
	logic [DIV_VW-1:0] rem_next;

	// one restoring step per cycle
	assign shifted  = {rem_q, quo_q[DIV_DW-1]};
	assign ge       = (shifted >= {1'b0, dvs_q});
	assign diff     = shifted - {1'b0, dvs_q};
	assign rem_next = ge ? diff[DIV_VW-1:0] : shifted[DIV_VW-1:0];

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_DW-2:0], ge};
			rem_q <= rem_next;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_DW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/vmb_back.sv
module vmb_back import vmb_pkg::*; #(
	parameter int MAX_LEDS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               lq_empty,
	input  logic [LEVEL_W-1:0] lq_data,
	output logic               lq_pop,
	output div_req_t           div_req,
	input  div_rsp_t           div_rsp,
	input  logic               pop,
	output logic               empty,
	output logic [CHAN_W-1:0]  channel,
	output logic [BRI_W-1:0]   brightness,
	output logic               last
);

	localparam int N_W = $clog2(MAX_LEDS + 1);

	back_state_t         state_q;
	back_state_t         state_n;
	logic [LEVEL_W-1:0]  held_q;
	logic [N_W-1:0]      n_q;
	logic [N_W-1:0]      full_q;
	logic [N_W-1:0]      idx_q;
	logic [DIV_VW-1:0]   span_q;
	logic [LEVEL_W-1:0]  rem_q;
	logic [BRI_W-1:0]    max_q;
	logic [FCH_W-1:0]    first_q;
	logic [BRI_W-1:0]    partial_q;
	logic                out_valid_q;
	logic [CHAN_W-1:0]   channel_q;
	logic [BRI_W-1:0]    bri_q;
	logic                last_q;
	logic [N_W-1:0]      n_eff;
	logic [LEVEL_W+N_W-1:0] full_prod;
	logic                out_load;
	logic                idx_last;
	logic [BRI_W-1:0]    bri_now;

	// clamp the led count to 1..MAX_LEDS
	always_comb begin
		priority if (cfg.led_count == '0) begin
			n_eff = N_W'(1);
		end else if (int'(cfg.led_count) > MAX_LEDS) begin
			n_eff = N_W'(MAX_LEDS);
		end else begin
			n_eff = N_W'(cfg.led_count);
		end
	end

	assign full_prod = {{N_W{1'b0}}, held_q} * {{LEVEL_W{1'b0}}, n_eff};
	assign idx_last  = (idx_q == n_q - N_W'(1));

	// brightness of the current led
	always_comb begin
		priority if (idx_q < full_q) begin
			bri_now = max_q;
		end else if (idx_q == full_q) begin
			bri_now = partial_q;
		end else begin
			bri_now = '0;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_n          = state_q;
		lq_pop           = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!lq_empty) begin
					lq_pop  = 1'b1;
					state_n = BK_FULL;
				end
			end
			BK_FULL: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_DW'(1) << FRAC_BITS;
				div_req.divisor  = DIV_VW'(n_eff);
				state_n          = BK_SPAN;
			end
			BK_SPAN: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_DW'(full_q) << FRAC_BITS;
					div_req.divisor  = DIV_VW'(n_q);
					state_n          = BK_QUOT;
				end
			end
			BK_QUOT: begin
				if (div_rsp.done) begin
					state_n = BK_PROD;
				end
			end
			BK_PROD: begin
				div_req.start    = 1'b1;
				div_req.dividend = {{BRI_W{1'b0}}, rem_q} * {{LEVEL_W{1'b0}}, max_q};
				div_req.divisor  = span_q;
				state_n          = BK_PART;
			end
			BK_PART: begin
				if (div_rsp.done) begin
					state_n = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					if (idx_last) begin
						state_n = BK_IDLE;
					end
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// per-sample working registers
	always_ff @(posedge clk) begin
		if (lq_pop) begin
			held_q <= lq_data;
		end
		if (state_q == BK_FULL) begin
			n_q     <= n_eff;
			full_q  <= full_prod[FRAC_BITS +: N_W];
			max_q   <= cfg.max_brightness;
			first_q <= cfg.first_channel;
		end
		if (state_q == BK_SPAN && div_rsp.done) begin
			span_q <= div_rsp.quotient[DIV_VW-1:0];
		end
		if (state_q == BK_QUOT && div_rsp.done) begin
			rem_q <= held_q - div_rsp.quotient[LEVEL_W-1:0];
		end
		if (state_q == BK_PART && div_rsp.done) begin
			partial_q <= (div_rsp.quotient > DIV_DW'(max_q)) ?
				max_q : div_rsp.quotient[BRI_W-1:0];
			idx_q     <= '0;
		end else if (out_load) begin
			idx_q <= idx_q + N_W'(1);
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (out_load) begin
			channel_q <= CHAN_W'(first_q) + CHAN_W'(idx_q);
			bri_q     <= bri_now;
			last_q    <= idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty      = !out_valid_q;
	assign channel    = channel_q;
	assign brightness = bri_q;
	assign last       = last_q;

endmodule

// File: hdl/vu_meter_bar_graph.sv
// LED bar-graph VU meter. Each pushed item (a 10-bit level and a millisecond
// timestamp) updates the held level at once in the front end: gain in Q10,
// saturation at 1023, trigger with hold-off, otherwise linear decay. The held
// level then waits in a four-entry queue, so up to four items are taken one
// per cycle while the bar generator is busy. The bar generator turns each held
// level into one item per LED, bottom LED first, with last set on the top LED.
// It needs three divisions per item on one shared bit-serial divider of 22
// steps each, and takes no new held level before the top LED item of the
// current one is loaded. The user must write registers only while the block
// is idle, not enforced by the block; there is no clearing pass after reset.
module vu_meter_bar_graph import vmb_pkg::*; #(
	parameter int MAX_LEDS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [LEVEL_W-1:0]    level,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAN_W-1:0]     channel,
	output logic [BRI_W-1:0]      brightness,
	output logic                  last
);

	cfg_t               cfg_q;
	logic               accept;
	logic [LEVEL_W-1:0] held_next;
	logic               lq_full;
	logic               lq_empty;
	logic               lq_pop;
	logic [LEVEL_W-1:0] lq_data;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain           <= GAIN_RST;
			cfg_q.trigger_level  <= TRIG_RST;
			cfg_q.decay_step     <= DECAY_RST;
			cfg_q.holdoff_ms     <= HOLD_RST;
			cfg_q.max_brightness <= MAXBRI_RST;
			cfg_q.led_count      <= LEDCNT_RST;
			cfg_q.first_channel  <= FIRSTCH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN:           cfg_q.gain           <= cfg_data[GAIN_W-1:0];
				REG_TRIGGER_LEVEL:  cfg_q.trigger_level  <= cfg_data[LEVEL_W-1:0];
				REG_DECAY_STEP:     cfg_q.decay_step     <= cfg_data[LEVEL_W-1:0];
				REG_HOLDOFF_MS:     cfg_q.holdoff_ms     <= cfg_data[HOLD_W-1:0];
				REG_MAX_BRIGHTNESS: cfg_q.max_brightness <= cfg_data[BRI_W-1:0];
				REG_LED_COUNT:      cfg_q.led_count      <= cfg_data[CNT_W-1:0];
				REG_FIRST_CHANNEL:  cfg_q.first_channel  <= cfg_data[FCH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input side
	assign full   = lq_full;
	assign accept = push && !lq_full;

	vmb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.level     (level),
		.now_ms    (now_ms),
		.held_next (held_next)
	);

	vmb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wdata  (held_next),
		.rd_en  (lq_pop),
		.rdata  (lq_data),
		.full   (lq_full),
		.empty  (lq_empty)
	);

	vmb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	vmb_back #(
		.MAX_LEDS (MAX_LEDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.lq_empty   (lq_empty),
		.lq_data    (lq_data),
		.lq_pop     (lq_pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.pop        (pop),
		.empty      (empty),
		.channel    (channel),
		.brightness (brightness),
		.last       (last)
	);

endmodule

// File: hdl/vmb_checker.sv
module vmb_checker import vmb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              pop,
	input logic              empty,
	input logic [CHAN_W-1:0] channel,
	input logic [BRI_W-1:0]  brightness,
	input logic              last
);

	logic              mid_bar_q;
	logic [CHAN_W-1:0] prev_chan_q;
	logic [BRI_W-1:0]  prev_bri_q;

	// remember the previous item of the current bar
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_bar_q <= 1'b0;
		end else if (pop && !empty) begin
			mid_bar_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !empty) begin
			prev_chan_q <= channel;
			prev_bri_q  <= brightness;
		end
	end

	// a waiting item holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(channel) && $stable(brightness) &&
			$stable(last)))
		else $error("result item changed while waiting");

	// leds of one bar come on consecutive channels
	a_chan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mid_bar_q) |-> (channel == prev_chan_q + 1'b1))
		else $error("channel did not advance by one within a bar");

	// a bar never gets brighter going up
	a_bri_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && mid_bar_q) |-> (brightness <= prev_bri_q))
		else $error("brightness rose within a bar");

endmodule

bind vu_meter_bar_graph vmb_checker u_vmb_checker (.*);
